/* design/gpu_bitfield_align_alu_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the bit-field / align ALU
// Concurrent checks clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef GPU_BITFIELD_ALIGN_ALU_UNIT_MACROS_SVH
`define GPU_BITFIELD_ALIGN_ALU_UNIT_MACROS_SVH

// same-cycle implication
`define GBA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GBA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/gba_pkg.sv */
// ----------------------------------------------------------------------------
// gba_pkg
// Opcodes and stage payload types of the bit-field / align ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package gba_pkg;

	typedef enum logic [2:0] {
		OP_SBFE_U    = 3'd0,
		OP_SBFE_I    = 3'd1,
		OP_VBFE_U    = 3'd2,
		OP_VBFE_I    = 3'd3,
		OP_BFM       = 3'd4,
		OP_BFI       = 3'd5,
		OP_ALIGNBIT  = 3'd6,
		OP_ALIGNBYTE = 3'd7
	} op_t;

	// decode stage payload
	typedef struct packed {
		op_t         op;
		logic [63:0] funnel;  // {hi, lo} operand of the right shifter
		logic [5:0]  shamt;   // right shift amount, 0..63
		logic [5:0]  width;   // field or mask width, 0..32
		logic [4:0]  off;     // mask offset for bfm
		logic [31:0] aux;     // base data for bfi
	} dec_t;

	// shift stage payload
	typedef struct packed {
		op_t         op;
		logic [31:0] shifted; // shifted word, or bfi result
		logic [31:0] mask;    // width ones from bit 0
		logic [5:0]  width;
		logic [4:0]  off;
	} shf_t;

	// result payload
	typedef struct packed {
		logic        cond_written;
		logic        cond_flag;
		logic [31:0] result;
	} res_t;

endpackage

`default_nettype wire

/* design/gba_decode.sv */
// ----------------------------------------------------------------------------
// gba_decode
// First stage: picks shifter operands, clamps the field width.
// ----------------------------------------------------------------------------
`default_nettype none

module gba_decode import gba_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire op_t         op,
	input  wire logic [31:0] src_a,
	input  wire logic [31:0] src_b,
	input  wire logic [31:0] src_c,
	output logic             out_valid,
	input  wire logic        out_ready,
	output dec_t             out_data
);

	logic       valid_s1;
	dec_t       data_s1;
	dec_t       dec_d;
	logic [4:0] ofs;
	logic [6:0] cnt;
	logic [5:0] lim;

	assign ofs = src_b[4:0];
	assign cnt = (op == OP_SBFE_U || op == OP_SBFE_I) ? src_b[22:16] : {2'b00, src_c[4:0]};
	assign lim = 6'd32 - {1'b0, ofs};

	always_comb begin
		dec_d        = '0;
		dec_d.op     = op;
		dec_d.funnel = {src_a, src_b};
		dec_d.aux    = src_c;
		unique case (op)
			OP_SBFE_U, OP_SBFE_I, OP_VBFE_U, OP_VBFE_I: begin
				dec_d.funnel = {32'd0, src_a};
				dec_d.shamt  = {1'b0, ofs};
				// clamp so the field stays inside bit 31
				dec_d.width  = (cnt > {1'b0, lim}) ? lim : cnt[5:0];
			end
			OP_BFM: begin
				dec_d.width = {1'b0, src_a[4:0]};
				dec_d.off   = ofs;
			end
			OP_BFI: begin
				dec_d.shamt = 6'd0;
			end
			OP_ALIGNBIT: begin
				dec_d.shamt = {1'b0, src_c[4:0]};
			end
			OP_ALIGNBYTE: begin
				// counts of eight bytes and more give zero
				if (src_c[4:3] != 2'b00) begin
					dec_d.funnel = '0;
				end
				dec_d.shamt = {src_c[2:0], 3'b000};
			end
		endcase
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= dec_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

`default_nettype wire

/* design/gba_shift.sv */
// ----------------------------------------------------------------------------
// gba_shift
// Second stage: 64-bit funnel shift right, mask build, select-insert.
// ----------------------------------------------------------------------------
`default_nettype none

module gba_shift import gba_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire dec_t in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output shf_t      out_data
);

	logic        valid_s2;
	shf_t        data_s2;
	shf_t        shf_d;
	logic [63:0] shr;
	logic [31:0] sel;

	assign shr = in_data.funnel >> in_data.shamt;
	assign sel = in_data.funnel[63:32];

	always_comb begin
		shf_d       = '0;
		shf_d.op    = in_data.op;
		shf_d.width = in_data.width;
		shf_d.off   = in_data.off;
		if (in_data.op == OP_BFI) begin
			shf_d.shifted = (sel & in_data.funnel[31:0]) | (~sel & in_data.aux);
		end else begin
			shf_d.shifted = shr[31:0];
		end
		if (in_data.width[5]) begin
			shf_d.mask = '1;
		end else begin
			shf_d.mask = (32'd1 << in_data.width[4:0]) - 32'd1;
		end
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s2 <= shf_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

`default_nettype wire

/* design/gba_merge.sv */
// ----------------------------------------------------------------------------
// gba_merge
// Third stage: applies mask and sign, places bfm mask, sets condition.
// ----------------------------------------------------------------------------
`default_nettype none

module gba_merge import gba_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire shf_t in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output res_t      out_data
);

	logic        valid_s3;
	res_t        data_s3;
	res_t        res_d;
	logic [31:0] field;
	logic [4:0]  sign_idx;
	logic        neg;
	logic        scalar;

	assign field    = in_data.shifted & in_data.mask;
	// width 32 wraps to index 31
	assign sign_idx = in_data.width[4:0] - 5'd1;
	assign neg      = (in_data.width != 6'd0) && in_data.shifted[sign_idx];
	assign scalar   = (in_data.op == OP_SBFE_U) || (in_data.op == OP_SBFE_I);

	always_comb begin
		res_d = '0;
		unique case (in_data.op)
			OP_SBFE_U, OP_VBFE_U: res_d.result = field;
			OP_SBFE_I, OP_VBFE_I: res_d.result = neg ? (field | ~in_data.mask) : field;
			OP_BFM:               res_d.result = in_data.mask << in_data.off;
			OP_BFI, OP_ALIGNBIT, OP_ALIGNBYTE: res_d.result = in_data.shifted;
		endcase
		res_d.cond_written = scalar;
		res_d.cond_flag    = scalar && (res_d.result != 32'd0);
	end

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s3 <= res_d;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

endmodule

`default_nettype wire

/* design/gpu_bitfield_align_alu_unit.sv */
// Each accepted item passes the decode, shift and merge stage registers on its way to m_tvalid.
// Throughput: one item per cycle while m_tready does not stall; each of the three is one stage.
// Backpressure: each stage holds its item while the stage after it is full and stalled.
// Reset: arst_n clears the three stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// gpu_bitfield_align_alu_unit
// Three-stage integer unit: bit-field extract, mask, insert, bit/byte align.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gpu_bitfield_align_alu_unit_macros.svh"

module gpu_bitfield_align_alu_unit import gba_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [95:0]  s_tdata,  // src_a[31:0], src_b[63:32], src_c[95:64]
	input  wire logic [2:0]   s_tuser,  // opcode[2:0]
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [39:0]       m_tdata   // result[31:0], cond_flag[32], cond_written[33], zero pad
);

	logic s1_valid, s2_ready, s2_valid, s3_ready;
	dec_t s1_data;
	shf_t s2_data;
	res_t s3_data;

	gba_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.op        (op_t'(s_tuser)),
		.src_a     (s_tdata[31:0]),
		.src_b     (s_tdata[63:32]),
		.src_c     (s_tdata[95:64]),
		.out_valid (s1_valid),
		.out_ready (s2_ready),
		.out_data  (s1_data)
	);

	gba_shift u_shift (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s1_valid),
		.in_ready  (s2_ready),
		.in_data   (s1_data),
		.out_valid (s2_valid),
		.out_ready (s3_ready),
		.out_data  (s2_data)
	);

	gba_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s2_valid),
		.in_ready  (s3_ready),
		.in_data   (s2_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (s3_data)
	);

	assign m_tdata = {6'd0, s3_data};

	`GBA_ASSERT_NXT(a_s1_advance, s1_valid && s2_ready, s2_valid, "item lost between decode and shift")
	`GBA_ASSERT_NXT(a_s2_hold, s2_valid && !s3_ready, s2_valid && $stable(s2_data), "stalled shift stage changed")
	`GBA_ASSERT_IMP(a_no_bubble, m_tready, s_tready, "input stalled while output drains")
	`GBA_ASSERT_IMP(a_cond, m_tvalid && s3_data.cond_written, s3_data.cond_flag == (s3_data.result != 32'd0), "condition flag mismatch")

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the bit-field / align ALU against a predictor of its own: a table of
// directed items first, then random items under changing idle and stall rates.
// ----------------------------------------------------------------------------
module testbench;
	import gba_pkg::*;

	localparam int DIR_COUNT   = 26;
	localparam int LONG_HOLD   = 60;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 8;

	typedef struct packed {
		op_t         op;
		logic [31:0] src_a;
		logic [31:0] src_b;
		logic [31:0] src_c;
		bit          typed;
		res_t        want;  // {cond_written, cond_flag, result}
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	res_t expected_results[$];
	int   mismatch_count = 0;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   hold_requests = 0;
	int   holds_served = 0;
	int   hold_left = 0;
	int   quiet_cycles = 0;

	stim_row_t directed_rows [DIR_COUNT] = '{
		'{OP_SBFE_U,    32'hffffffff, 32'h00200000, 32'h00000000, 1'b1, '{1'b1, 1'b1, 32'hffffffff}},
		'{OP_SBFE_U,    32'hffffffff, 32'h00000000, 32'h00000000, 1'b1, '{1'b1, 1'b0, 32'h00000000}},
		'{OP_SBFE_U,    32'h80000000, 32'h007f001f, 32'h00000000, 1'b1, '{1'b1, 1'b1, 32'h00000001}},
		'{OP_SBFE_I,    32'h80000000, 32'h0001001f, 32'h00000000, 1'b1, '{1'b1, 1'b1, 32'hffffffff}},
		'{OP_SBFE_I,    32'hffffffff, 32'h00000010, 32'h00000000, 1'b1, '{1'b1, 1'b0, 32'h00000000}},
		'{OP_SBFE_U,    32'h00000000, 32'hffffffff, 32'hffffffff, 1'b1, '{1'b1, 1'b0, 32'h00000000}},
		'{OP_SBFE_I,    32'h12345678, 32'h00080004, 32'h00000000, 1'b0, '0},
		'{OP_VBFE_U,    32'hffffffff, 32'h00000000, 32'h00000000, 1'b1, '{1'b0, 1'b0, 32'h00000000}},
		'{OP_VBFE_U,    32'hffffffff, 32'h00000000, 32'h0000001f, 1'b1, '{1'b0, 1'b0, 32'h7fffffff}},
		'{OP_VBFE_I,    32'h80000000, 32'hffffffff, 32'hffffffff, 1'b1, '{1'b0, 1'b0, 32'hffffffff}},
		'{OP_VBFE_I,    32'h00000008, 32'h00000000, 32'h00000004, 1'b1, '{1'b0, 1'b0, 32'hfffffff8}},
		'{OP_VBFE_I,    32'h80000000, 32'h00000000, 32'h00000000, 1'b1, '{1'b0, 1'b0, 32'h00000000}},
		'{OP_VBFE_U,    32'ha5a5a5a5, 32'h00000007, 32'h0000000c, 1'b0, '0},
		'{OP_BFM,       32'h00000000, 32'h00000000, 32'h00000000, 1'b1, '{1'b0, 1'b0, 32'h00000000}},
		'{OP_BFM,       32'h0000001f, 32'h00000000, 32'h00000000, 1'b1, '{1'b0, 1'b0, 32'h7fffffff}},
		'{OP_BFM,       32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b1, '{1'b0, 1'b0, 32'h80000000}},
		'{OP_BFI,       32'hffffffff, 32'h12345678, 32'h00000000, 1'b1, '{1'b0, 1'b0, 32'h12345678}},
		'{OP_BFI,       32'h00000000, 32'h12345678, 32'hcafef00d, 1'b1, '{1'b0, 1'b0, 32'hcafef00d}},
		'{OP_BFI,       32'h0f0f0f0f, 32'hffffffff, 32'h00000000, 1'b1, '{1'b0, 1'b0, 32'h0f0f0f0f}},
		'{OP_ALIGNBIT,  32'hffffffff, 32'h00000000, 32'h00000000, 1'b1, '{1'b0, 1'b0, 32'h00000000}},
		'{OP_ALIGNBIT,  32'hffffffff, 32'h00000000, 32'h0000001f, 1'b1, '{1'b0, 1'b0, 32'hfffffffe}},
		'{OP_ALIGNBIT,  32'h89abcdef, 32'h01234567, 32'hffffffe4, 1'b0, '0},
		'{OP_ALIGNBYTE, 32'hffffffff, 32'h12345678, 32'h00000000, 1'b1, '{1'b0, 1'b0, 32'h12345678}},
		'{OP_ALIGNBYTE, 32'hffffffff, 32'h00000000, 32'h00000007, 1'b1, '{1'b0, 1'b0, 32'h000000ff}},
		'{OP_ALIGNBYTE, 32'hffffffff, 32'h00000000, 32'h00000008, 1'b1, '{1'b0, 1'b0, 32'h00000000}},
		'{OP_ALIGNBYTE, 32'h89abcdef, 32'h01234567, 32'hffffffe4, 1'b1, '{1'b0, 1'b0, 32'h89abcdef}}
	};

	gpu_bitfield_align_alu_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// clamp the width to what fits above the offset, then sign-fill if asked
	function automatic logic [31:0] extract_field(logic [31:0] value, logic [4:0] offset,
			int unsigned count, bit sign_fill);
		int unsigned room;
		logic [31:0] mask;
		logic [31:0] bits;
		room = 32 - offset;
		if (count > room)
			count = room;
		if (count == 0)
			return 32'd0;
		mask = (count == 32) ? 32'hffffffff : ((32'd1 << count) - 32'd1);
		bits = (value >> offset) & mask;
		if (sign_fill && bits[count - 1])
			bits = bits | ~mask;
		return bits;
	endfunction

	function automatic res_t alu_expected(op_t op, logic [31:0] a, logic [31:0] b,
			logic [31:0] c);
		res_t        r;
		logic [63:0] pair;
		logic [31:0] ones;
		pair = {a, b};
		r = '0;
		case (op)
			OP_SBFE_U, OP_SBFE_I: begin
				r.result = extract_field(a, b[4:0], b[22:16], op == OP_SBFE_I);
				r.cond_written = 1'b1;
				r.cond_flag = (r.result != 32'd0);
			end
			OP_VBFE_U, OP_VBFE_I: begin
				r.result = extract_field(a, b[4:0], c[4:0], op == OP_VBFE_I);
			end
			OP_BFM: begin
				ones = (32'd1 << a[4:0]) - 32'd1;
				r.result = ones << b[4:0];
			end
			OP_BFI: begin
				r.result = (a & b) | (~a & c);
			end
			OP_ALIGNBIT: begin
				r.result = 32'(pair >> c[4:0]);
			end
			default: begin
				r.result = (c[4:0] < 5'd8) ? 32'(pair >> ({3'd0, c[2:0]} * 6'd8)) : 32'd0;
			end
		endcase
		return r;
	endfunction

	function automatic logic [31:0] corner_word();
		case ($urandom_range(7))
			0: return 32'h00000000;
			1: return 32'hffffffff;
			2: return 32'h80000000;
			3: return 32'h7fffffff;
			default: return $urandom;
		endcase
	endfunction

	// offer one item, idling first at the current rate; leave tvalid high on return
	task automatic offer_item(input op_t op, input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c, input bit typed, input res_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {c, b, a};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		expected_results.push_back(typed ? want : alu_expected(op, a, b, c));
	endtask

	task automatic send_random(input int count, input int idle_pct, input int stall_pct,
			input int hold_at);
		op_t         op;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < count; i++) begin
			if (i == hold_at)
				hold_requests <= hold_requests + 1;
			op = op_t'($urandom_range(7));
			a = corner_word();
			b = $urandom;
			c = $urandom;
			if ((op == OP_SBFE_U || op == OP_SBFE_I) && $urandom_range(1))
				b[22:16] = 7'($urandom_range(33));
			if (op == OP_ALIGNBYTE && $urandom_range(1))
				c[4:0] = 5'($urandom_range(7));
			if (op == OP_BFI && $urandom_range(1))
				c = corner_word();
			offer_item(op, a, b, c, 1'b0, '0);
		end
	endtask

	task automatic wait_drained();
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_requests != holds_served) begin
				holds_served++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : result_check
		res_t seen;
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			seen = res_t'(m_tdata[33:0]);
			if (expected_results.size() == 0) begin
				$error("unexpected item: result %h", seen.result);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				if (seen.result !== want.result) begin
					$error("result: expected %h, actual %h", want.result, seen.result);
					mismatch_count++;
				end
				if (seen.cond_flag !== want.cond_flag) begin
					$error("cond_flag: expected %b, actual %b", want.cond_flag, seen.cond_flag);
					mismatch_count++;
				end
				if (seen.cond_written !== want.cond_written) begin
					$error("cond_written: expected %b, actual %b", want.cond_written,
						seen.cond_written);
					mismatch_count++;
				end
			end
		end
	end

	// end the run when nothing moves on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_COUNT; i++)
			offer_item(directed_rows[i].op, directed_rows[i].src_a, directed_rows[i].src_b,
				directed_rows[i].src_c, directed_rows[i].typed, directed_rows[i].want);

		// keep offering while the receiver holds off, so the pipe fills and stalls
		send_random(100, 0, 0, 20);
		send_random(110, 79, 0, -1);
		// hold the input until every result is back
		s_tvalid <= 1'b0;
		wait_drained();
		@(posedge clk);
		send_random(110, 0, 79, -1);
		send_random(130, 11, 11, -1);
		s_tvalid <= 1'b0;

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
